// ===== design/gwf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared types, constants and the stable-split function of the grid water
// flow block.
// ----------------------------------------------------------------------------
package gwf_pkg;

    localparam int GRID_W  = 16;
    localparam int GRID_H  = 16;
    localparam int COL_W   = 4;
    localparam int ROW_W   = 4;
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int CELLS   = GRID_W * GRID_H;
    localparam int MASS_W  = 16;
    localparam int ONE     = 256;
    localparam int MAXMASS = 256;
    localparam int MAXCOMP = 5;
    localparam int STEP_D  = MAXMASS + MAXCOMP;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [1:0] CFG_MIN_FLOW  = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
    localparam logic [1:0] CFG_MIN_MASS  = 2'd2;

    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              set_ground;
        logic [MASS_W-1:0] set_mass;
    } cmd_t;

    typedef struct packed {
        logic              is_ground;
        logic              is_water;
        logic [MASS_W-1:0] mass;
        logic              done_res;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP,
        ST_CELL_RD,
        ST_CELL_CHK,
        ST_NB_RD,
        ST_NB_CALC,
        ST_MOVE,
        ST_WB,
        ST_ADV,
        ST_COPY,
        ST_COPY_END,
        ST_CLEAR
    } st_t;

    // stable amount of the lower cell for a total mass t
    function automatic logic [MASS_W:0] stable_of(input logic [MASS_W:0] t);
        logic [MASS_W:0] d;
        logic [2:0]      q;
        logic [MASS_W+1:0] h;
        d = '0;
        q = '0;
        h = '0;
        if (t <= (MASS_W+1)'(ONE)) begin
            return (MASS_W+1)'(ONE);
        end
        else if (t < (MASS_W+1)'(2 * MAXMASS + MAXCOMP)) begin
            // result is 256 plus the quotient 5*(t-256) over 261, which is at most 4
            d = (MASS_W+1)'((t - (MASS_W+1)'(ONE)) * (MASS_W+1)'(MAXCOMP));
            q = 3'(d >= (MASS_W+1)'(STEP_D)) + 3'(d >= (MASS_W+1)'(2 * STEP_D))
              + 3'(d >= (MASS_W+1)'(3 * STEP_D)) + 3'(d >= (MASS_W+1)'(4 * STEP_D));
            return (MASS_W+1)'(MAXMASS) + (MASS_W+1)'(q);
        end
        else begin
            h = {1'b0, t} + (MASS_W+2)'(MAXCOMP);
            return h[MASS_W+1:1];
        end
    endfunction

endpackage

// ===== design/gwf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwf_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module gwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/grid_water_flow_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_water_flow_step
// Cellular-automaton water flow over a 16 x 16 grid held in block RAM.
//
// Command channel (cmd_valid/cmd_ready/cmd): one transaction per command.
// write sets a cell, read returns a cell, step runs one flow update.
// Result channel (res_valid/res_ready/res): exactly one transaction per
// command, held in an output register until taken.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready,
// write only while no command is in flight.
// A step walks the cells column by column: a ground or empty cell is read,
// checked and skipped; a wet cell runs neighbor read, flow and update for
// up to 4 directions (down, left, right, up) through the single read port
// of the mass RAMs and writes back its own new mass; a final sweep then
// commits the new masses and water flags.
// One command at a time: cmd_ready is high only when the block is idle.
// A stalled result channel holds the finished result; the block waits.
// Reset starts a clearing pass that zeroes every cell; cmd_ready stays low
// until it ends.
// ----------------------------------------------------------------------------
module grid_water_flow_step
    import gwf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    st_t state_reg, state_next;

    logic [7:0]  min_flow_reg;
    logic [11:0] max_speed_reg;
    logic [7:0]  min_mass_reg;

    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        dir_reg, dir_next;
    logic [MASS_W-1:0] rem_reg, rem_next;
    logic [MASS_W-1:0] cm_reg, cm_next;
    logic [MASS_W-1:0] ni_reg, ni_next;
    logic [MASS_W-1:0] nnext_reg, nnext_next;
    logic signed [MASS_W+2:0] raw_reg, raw_next;
    logic [ADDR_W-1:0] nb_addr_reg, nb_addr_next;
    logic              nb_in_reg, nb_in_next;
    logic              cp_v_reg, cp_v_next;
    logic [ADDR_W-1:0] cp_addr_reg, cp_addr_next;
    res_t              pend_reg, pend_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;
    logic              ok_reg;

    // ram ports
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in;
    logic              old_we, next_we;
    logic [ADDR_W-1:0] old_waddr, next_waddr;
    logic [MASS_W:0]   old_wdata, old_q;
    logic [MASS_W-1:0] next_wdata, next_q;
    logic              water_wdata, water_q;

    gwf_ram #(.WIDTH(MASS_W + 1), .DEPTH(CELLS)) u_old_ram (
        .clk   (clk),
        .we    (old_we),
        .waddr (old_waddr),
        .wdata (old_wdata),
        .raddr (rd_addr),
        .rdata (old_q)
    );

    gwf_ram #(.WIDTH(MASS_W), .DEPTH(CELLS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_q)
    );

    gwf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_water_ram (
        .clk   (clk),
        .we    (old_we),
        .waddr (old_waddr),
        .wdata (water_wdata),
        .raddr (rd_addr),
        .rdata (water_q)
    );

    // current step cell
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ADDR_W-1:0] cur_idx;
    assign cur_col = cnt_reg[ADDR_W-1:ROW_W];
    assign cur_row = cnt_reg[ROW_W-1:0];
    assign cur_idx = {cur_row, cur_col};

    // neighbor of the current cell in the current direction
    logic [ADDR_W-1:0] nb_addr;
    logic              nb_in;
    always_comb
    begin
        nb_addr = cur_idx;
        nb_in   = 1'b0;
        unique case (dir_reg)
            DIR_DOWN:
            begin
                nb_addr = {cur_row + ROW_W'(1), cur_col};
                nb_in   = cur_row != ROW_W'(GRID_H - 1);
            end
            DIR_LEFT:
            begin
                nb_addr = {cur_row, cur_col - COL_W'(1)};
                nb_in   = cur_col != '0;
            end
            DIR_RIGHT:
            begin
                nb_addr = {cur_row, cur_col + COL_W'(1)};
                nb_in   = cur_col != COL_W'(GRID_W - 1);
            end
            DIR_UP:
            begin
                nb_addr = {cur_row - ROW_W'(1), cur_col};
                nb_in   = cur_row != '0;
            end
            default:
            begin
                nb_addr = cur_idx;
                nb_in   = 1'b0;
            end
        endcase
    end

    // gated read data, off-grid cells read as zero
    logic              rd_gnd;
    logic [MASS_W-1:0] rd_mass, rd_next;
    assign rd_gnd  = ok_reg & old_q[MASS_W];
    assign rd_mass = ok_reg ? old_q[MASS_W-1:0] : '0;
    assign rd_next = ok_reg ? next_q : '0;

    // flow arithmetic
    logic [MASS_W:0]          tot, stab;
    logic signed [MASS_W+2:0] diff;
    logic [MASS_W:0]          fpos, fhalf;
    logic [MASS_W-1:0]        cap, flow;
    logic                     vert;
    logic [MASS_W:0]          nb_sum;
    logic                     cmd_inside;

    assign tot  = {1'b0, rem_reg} + {1'b0, rd_mass};
    assign stab = stable_of(tot);
    assign diff = $signed({3'b000, cm_reg}) - $signed({3'b000, rd_mass});
    assign fpos = (raw_reg > 0) ? raw_reg[MASS_W:0] : '0;
    assign fhalf = (fpos > (MASS_W+1)'(min_flow_reg)) ? (fpos >> 1) : fpos;
    assign vert = (dir_reg == DIR_DOWN) || (dir_reg == DIR_UP);
    assign cap  = (vert && (MASS_W'(max_speed_reg) < rem_reg)) ?
                  MASS_W'(max_speed_reg) : rem_reg;
    assign flow = (fhalf > {1'b0, cap}) ? cap : fhalf[MASS_W-1:0];
    assign nb_sum = {1'b0, nnext_reg} + {1'b0, flow};
    assign cmd_inside = (32'(cmd.col) < GRID_W) && (32'(cmd.row) < GRID_H);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dir_next       = dir_reg;
        rem_next       = rem_reg;
        cm_next        = cm_reg;
        ni_next        = ni_reg;
        nnext_next     = nnext_reg;
        raw_next       = raw_reg;
        nb_addr_next   = nb_addr_reg;
        nb_in_next     = nb_in_reg;
        cp_v_next      = 1'b0;
        cp_addr_next   = cp_addr_reg;
        pend_next      = pend_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        cmd_ready      = 1'b0;
        rd_addr        = '0;
        rd_in          = 1'b1;
        old_we         = 1'b0;
        old_waddr      = '0;
        old_wdata      = '0;
        water_wdata    = 1'b0;
        next_we        = 1'b0;
        next_waddr     = '0;
        next_wdata     = '0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        // commit sweep write stage, one cell behind the read
        if (cp_v_reg)
        begin
            old_we      = 1'b1;
            old_waddr   = cp_addr_reg;
            old_wdata   = {rd_gnd, rd_next};
            water_wdata = !rd_gnd && (rd_next > MASS_W'(min_mass_reg));
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                old_we      = 1'b1;
                old_waddr   = cnt_reg;
                old_wdata   = '0;
                water_wdata = 1'b0;
                next_we     = 1'b1;
                next_waddr  = cnt_reg;
                next_wdata  = '0;
                cnt_next    = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                rd_addr   = {cmd.row, cmd.col};
                rd_in     = cmd_inside;
                if (cmd_valid)
                begin
                    pend_next = '0;
                    case (cmd.opcode)
                        OP_WRITE:
                        begin
                            pend_next.done_res = 1'b1;
                            if (cmd_inside)
                            begin
                                old_we      = 1'b1;
                                old_waddr   = {cmd.row, cmd.col};
                                old_wdata   = {cmd.set_ground, cmd.set_mass};
                                water_wdata = !cmd.set_ground &&
                                              (cmd.set_mass > MASS_W'(min_mass_reg));
                                next_we     = 1'b1;
                                next_waddr  = {cmd.row, cmd.col};
                                next_wdata  = cmd.set_mass;
                            end
                            state_next = ST_RESP;
                        end
                        OP_STEP:
                        begin
                            pend_next.done_res = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_CELL_RD;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                pend_next.is_ground = rd_gnd;
                pend_next.is_water  = ok_reg & water_q;
                pend_next.mass      = rd_mass;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_next       = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_CELL_RD:
            begin
                rd_addr    = cur_idx;
                state_next = ST_CELL_CHK;
            end
            ST_CELL_CHK:
            begin
                if (rd_gnd || (rd_mass == '0))
                begin
                    state_next = ST_ADV;
                end
                else
                begin
                    rem_next   = rd_mass;
                    cm_next    = rd_mass;
                    ni_next    = rd_next;
                    dir_next   = DIR_DOWN;
                    state_next = ST_NB_RD;
                end
            end
            ST_NB_RD:
            begin
                rd_addr      = nb_addr;
                rd_in        = nb_in;
                nb_addr_next = nb_addr;
                nb_in_next   = nb_in;
                state_next   = ST_NB_CALC;
            end
            ST_NB_CALC:
            begin
                nnext_next = rd_next;
                if (rd_gnd)
                begin
                    // solid neighbor takes no water
                    if (dir_reg == DIR_UP)
                    begin
                        state_next = ST_WB;
                    end
                    else
                    begin
                        dir_next   = dir_reg + 2'd1;
                        state_next = ST_NB_RD;
                    end
                end
                else
                begin
                    case (dir_reg)
                        DIR_DOWN:
                            raw_next = $signed({2'b00, stab}) - $signed({3'b000, rd_mass});
                        DIR_UP:
                            raw_next = $signed({3'b000, rem_reg}) - $signed({2'b00, stab});
                        default:
                            raw_next = (diff > 0) ? (diff >>> 2) : '0;
                    endcase
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                if (nb_in_reg)
                begin
                    next_we    = 1'b1;
                    next_waddr = nb_addr_reg;
                    next_wdata = nb_sum[MASS_W] ? '1 : nb_sum[MASS_W-1:0];
                end
                ni_next  = (ni_reg >= flow) ? (ni_reg - flow) : '0;
                rem_next = rem_reg - flow;
                if ((rem_reg == flow) || (dir_reg == DIR_UP))
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_NB_RD;
                end
            end
            ST_WB:
            begin
                next_we    = 1'b1;
                next_waddr = cur_idx;
                next_wdata = ni_reg;
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_COPY;
                end
                else
                begin
                    state_next = ST_CELL_RD;
                end
            end
            ST_COPY:
            begin
                rd_addr      = cnt_reg;
                cp_v_next    = 1'b1;
                cp_addr_next = cnt_reg;
                cnt_next     = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_COPY_END;
                end
            end
            ST_COPY_END:
            begin
                state_next = ST_RESP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            res_valid_reg <= 1'b0;
            cp_v_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            cnt_reg       <= '0;
            dir_reg       <= DIR_DOWN;
            min_flow_reg  <= 8'd3;
            max_speed_reg <= 12'd256;
            min_mass_reg  <= 8'd1;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            cp_v_reg      <= cp_v_next;
            cnt_reg       <= cnt_next;
            dir_reg       <= dir_next;
            ok_reg        <= rd_in;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MIN_FLOW:  min_flow_reg  <= cfg_data[7:0];
                    CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                    CFG_MIN_MASS:  min_mass_reg  <= cfg_data[7:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        cm_reg      <= cm_next;
        ni_reg      <= ni_next;
        nnext_reg   <= nnext_next;
        raw_reg     <= raw_next;
        nb_addr_reg <= nb_addr_next;
        nb_in_reg   <= nb_in_next;
        cp_addr_reg <= cp_addr_next;
        pend_reg    <= pend_next;
        res_reg     <= res_next;
    end

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
